>>> sv/amc_pkg.sv
package amc_pkg;

    localparam int MEM_DEPTH     = 256;
    localparam int WORD_BITS     = 16;
    localparam int ADDR_BITS     = $clog2(MEM_DEPTH);
    localparam int CNT_BITS      = $clog2(WORD_BITS);
    localparam int FIELD_BITS    = 16;
    localparam int PC_FIELD_BITS = 8;
    localparam int KIND_BITS     = 2;
    localparam int STATUS_BITS   = 2;

    typedef logic signed [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_BITS-1:0]        addr_t;

    // item kinds
    localparam logic [KIND_BITS-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_BITS-1:0] KIND_EXEC  = 2'd1;
    localparam logic [KIND_BITS-1:0] KIND_READ  = 2'd2;

    // halt codes
    localparam logic [STATUS_BITS-1:0] ST_RUN     = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_STOP    = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_DIV0    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_ILLEGAL = 2'd3;

    // opcodes
    localparam word_t OP_ADD    = word_t'(1);
    localparam word_t OP_SUB    = word_t'(2);
    localparam word_t OP_MUL    = word_t'(3);
    localparam word_t OP_DIV    = word_t'(4);
    localparam word_t OP_JMP    = word_t'(5);
    localparam word_t OP_JMPN   = word_t'(6);
    localparam word_t OP_JMPP   = word_t'(7);
    localparam word_t OP_JMPZ   = word_t'(8);
    localparam word_t OP_COPY   = word_t'(9);
    localparam word_t OP_LOAD   = word_t'(10);
    localparam word_t OP_STORE  = word_t'(11);
    localparam word_t OP_INPUT  = word_t'(12);
    localparam word_t OP_OUTPUT = word_t'(13);
    localparam word_t OP_STOP   = word_t'(14);

    typedef struct packed {
        logic  we;
        addr_t waddr;
        word_t wdata;
        logic  re;
        addr_t raddr;
    } mem_req_t;

    typedef struct packed {
        logic [PC_FIELD_BITS-1:0]     pc;
        logic signed [FIELD_BITS-1:0] acc;
        logic [STATUS_BITS-1:0]       status;
        logic                         out_valid;
        logic signed [FIELD_BITS-1:0] out_value;
        logic signed [FIELD_BITS-1:0] read_data;
    } result_t;

endpackage

>>> sv/amc_mem.sv
module amc_mem (
    input  logic              clk,
    input  amc_pkg::mem_req_t req,
    output amc_pkg::word_t    rd_data
);
    import amc_pkg::*;

    word_t ram_reg [MEM_DEPTH];
    word_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            ram_reg[req.waddr] <= req.wdata;
        end
        if (req.re)
        begin
            rd_data_reg <= ram_reg[req.raddr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> sv/amc_div.sv
module amc_div (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  amc_pkg::word_t dividend,
    input  amc_pkg::word_t divisor,
    output logic           busy,
    output logic           done,
    output amc_pkg::word_t quotient
);
    import amc_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [WORD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [WORD_BITS:0]   shifted;
    logic [WORD_BITS:0]   diff;
    logic                 last;

    assign shifted = {rem_reg, quo_reg[WORD_BITS-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign last    = (cnt_reg == CNT_BITS'(WORD_BITS - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            // work on magnitudes, fix the sign at the end
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[WORD_BITS-1] ? -dividend : dividend;
            dvs_next  = divisor[WORD_BITS-1] ? -divisor : divisor;
            neg_next  = dividend[WORD_BITS-1] ^ divisor[WORD_BITS-1];
        end
        else if (busy_reg)
        begin
            rem_next = diff[WORD_BITS] ? shifted[WORD_BITS-1:0] : diff[WORD_BITS-1:0];
            quo_next = {quo_reg[WORD_BITS-2:0], ~diff[WORD_BITS]};
            cnt_next = cnt_reg + CNT_BITS'(1);
            if (last)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = neg_reg ? -quo_reg : quo_reg;

    a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && last && !start) |=> (done_reg && !busy_reg))
        else $error("divider did not finish after last step");

    a_done_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held longer than one cycle");

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

endmodule

>>> sv/amc_ctrl.sv
module amc_ctrl (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [amc_pkg::KIND_BITS-1:0]      kind,
    input  logic [7:0]                         address,
    input  logic signed [amc_pkg::FIELD_BITS-1:0] data,
    output amc_pkg::mem_req_t                  mem_req,
    input  amc_pkg::word_t                     rd_data,
    output logic                               div_start,
    output amc_pkg::word_t                     div_dividend,
    output amc_pkg::word_t                     div_divisor,
    input  logic                               div_busy,
    input  logic                               div_done,
    input  amc_pkg::word_t                     div_quot,
    input  logic                               res_free,
    output logic                               res_push,
    output amc_pkg::result_t                   res
);
    import amc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDW  = 3'd1;
    localparam logic [2:0] S_OP   = 3'd2;
    localparam logic [2:0] S_OPA  = 3'd3;
    localparam logic [2:0] S_MEM  = 3'd4;
    localparam logic [2:0] S_OPB  = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_RESP = 3'd7;

    logic [2:0]             state_reg, state_next;
    addr_t                  pc_reg, pc_next;
    word_t                  acc_reg, acc_next;
    logic [STATUS_BITS-1:0] halt_reg, halt_next;
    word_t                  op_reg, op_next;
    addr_t                  a_reg, a_next;
    word_t                  val_reg, val_next;
    word_t                  data_reg, data_next;
    logic                   ov_reg, ov_next;
    word_t                  oval_reg, oval_next;
    word_t                  rdata_reg, rdata_next;
    logic                   accept;
    word_t                  product;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign product  = WORD_BITS'(acc_reg * rd_data);

    assign div_dividend = acc_reg;
    assign div_divisor  = rd_data;

    always_comb
    begin
        state_next = state_reg;
        pc_next    = pc_reg;
        acc_next   = acc_reg;
        halt_next  = halt_reg;
        op_next    = op_reg;
        a_next     = a_reg;
        val_next   = val_reg;
        data_next  = data_reg;
        ov_next    = ov_reg;
        oval_next  = oval_reg;
        rdata_next = rdata_reg;
        mem_req    = '0;
        div_start  = 1'b0;
        res_push   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    data_next  = WORD_BITS'(data);
                    ov_next    = 1'b0;
                    oval_next  = '0;
                    rdata_next = '0;
                    state_next = S_RESP;
                    case (kind)
                        KIND_WRITE:
                        begin
                            mem_req.we    = 1'b1;
                            mem_req.waddr = ADDR_BITS'(address);
                            mem_req.wdata = WORD_BITS'(data);
                        end
                        KIND_EXEC:
                        begin
                            // halted: report state, change nothing
                            if (halt_reg == ST_RUN)
                            begin
                                mem_req.re    = 1'b1;
                                mem_req.raddr = pc_reg;
                                state_next    = S_OP;
                            end
                        end
                        KIND_READ:
                        begin
                            mem_req.re    = 1'b1;
                            mem_req.raddr = ADDR_BITS'(address);
                            state_next    = S_RDW;
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end
            S_RDW:
            begin
                rdata_next = rd_data;
                state_next = S_RESP;
            end
            S_OP:
            begin
                op_next       = rd_data;
                mem_req.re    = 1'b1;
                mem_req.raddr = pc_reg + ADDR_BITS'(1);
                state_next    = S_OPA;
            end
            S_OPA:
            begin
                a_next        = rd_data[ADDR_BITS-1:0];
                mem_req.re    = 1'b1;
                mem_req.raddr = rd_data[ADDR_BITS-1:0];
                state_next    = S_MEM;
            end
            S_MEM:
            begin
                // rd_data holds the operand word m[a]
                state_next = S_RESP;
                pc_next    = pc_reg + ADDR_BITS'(2);
                case (op_reg)
                    OP_ADD:
                    begin
                        acc_next = acc_reg + rd_data;
                    end
                    OP_SUB:
                    begin
                        acc_next = acc_reg - rd_data;
                    end
                    OP_MUL:
                    begin
                        acc_next = product;
                    end
                    OP_DIV:
                    begin
                        if (rd_data == '0)
                        begin
                            halt_next = ST_DIV0;
                            pc_next   = pc_reg;
                        end
                        else
                        begin
                            div_start  = 1'b1;
                            pc_next    = pc_reg;
                            state_next = S_DIV;
                        end
                    end
                    OP_JMP:
                    begin
                        pc_next = a_reg;
                    end
                    OP_JMPN:
                    begin
                        if (acc_reg[WORD_BITS-1])
                        begin
                            pc_next = a_reg;
                        end
                    end
                    OP_JMPP:
                    begin
                        if (!acc_reg[WORD_BITS-1] && acc_reg != '0)
                        begin
                            pc_next = a_reg;
                        end
                    end
                    OP_JMPZ:
                    begin
                        if (acc_reg == '0)
                        begin
                            pc_next = a_reg;
                        end
                    end
                    OP_COPY:
                    begin
                        // hold the source word, fetch the destination address
                        val_next      = rd_data;
                        pc_next       = pc_reg;
                        mem_req.re    = 1'b1;
                        mem_req.raddr = pc_reg + ADDR_BITS'(2);
                        state_next    = S_OPB;
                    end
                    OP_LOAD:
                    begin
                        acc_next = rd_data;
                    end
                    OP_STORE:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = a_reg;
                        mem_req.wdata = acc_reg;
                    end
                    OP_INPUT:
                    begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = a_reg;
                        mem_req.wdata = data_reg;
                    end
                    OP_OUTPUT:
                    begin
                        ov_next   = 1'b1;
                        oval_next = rd_data;
                    end
                    OP_STOP:
                    begin
                        halt_next = ST_STOP;
                        pc_next   = pc_reg;
                    end
                    default:
                    begin
                        halt_next = ST_ILLEGAL;
                        pc_next   = pc_reg;
                    end
                endcase
            end
            S_OPB:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = rd_data[ADDR_BITS-1:0];
                mem_req.wdata = val_reg;
                pc_next       = pc_reg + ADDR_BITS'(3);
                state_next    = S_RESP;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    acc_next   = div_quot;
                    pc_next    = pc_reg + ADDR_BITS'(2);
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_free)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pc_reg    <= '0;
            acc_reg   <= '0;
            halt_reg  <= ST_RUN;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            acc_reg   <= acc_next;
            halt_reg  <= halt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        a_reg     <= a_next;
        val_reg   <= val_next;
        data_reg  <= data_next;
        ov_reg    <= ov_next;
        oval_reg  <= oval_next;
        rdata_reg <= rdata_next;
    end

    always_comb
    begin
        res.pc        = PC_FIELD_BITS'(pc_reg);
        res.acc       = FIELD_BITS'(acc_reg);
        res.status    = halt_reg;
        res.out_valid = ov_reg;
        res.out_value = FIELD_BITS'(oval_reg);
        res.read_data = FIELD_BITS'(rdata_reg);
    end

    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (halt_reg != ST_RUN) |=> (halt_reg != ST_RUN))
        else $error("halt code returned to running");

    a_halted_exec_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind == KIND_EXEC && halt_reg != ST_RUN)
            |=> (state_reg == S_RESP && $stable(pc_reg) && $stable(acc_reg)))
        else $error("halted block changed state on execute");

    a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_busy || div_done))
        else $error("waiting on divider that is not running");

    a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
        (mem_req.we && mem_req.re) |-> (mem_req.waddr != mem_req.raddr))
        else $error("read and write of the same word in one cycle");

endmodule

>>> sv/accumulator_machine_core.sv
// Accumulator machine core.
// Input channel (in_valid/in_ready) carries one item: kind, address, data.
//   kind write stores data at address, kind read returns the word at address,
//   kind execute runs the one instruction at the program counter.
// Result channel (res_valid/res_ready) returns one transfer per item with
//   pc, acc, status, out_valid/out_value (OUTPUT instruction) and read_data.
// Items are handled one at a time. State lives in a 256-word synchronous RAM
//   with one write and one read port and a registered read, so the cost of an
//   item is set by the chain of dependent RAM reads: execute fetches the opcode,
//   the operand address and the operand word in turn (COPY also the destination
//   address), and DIV then waits on the bit-serial divider (one quotient bit a
//   cycle over the word width).
// A result waits in an output register; the core keeps taking the next item
//   while it waits and stalls only when a second result is ready before the
//   first transfer completes.
// Reset clears pc, acc and the halt code and empties the output register.
//   Memory is not cleared: load the program before executing it.
// Once halted (STOP, zero divisor, illegal opcode) execute items report the
//   state unchanged; write and read items still work.
module accumulator_machine_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic [amc_pkg::KIND_BITS-1:0]          kind,
    input  logic [7:0]                             address,
    input  logic signed [amc_pkg::FIELD_BITS-1:0]  data,
    output logic                                   res_valid,
    input  logic                                   res_ready,
    output logic [amc_pkg::PC_FIELD_BITS-1:0]      pc,
    output logic signed [amc_pkg::FIELD_BITS-1:0]  acc,
    output logic [amc_pkg::STATUS_BITS-1:0]        status,
    output logic                                   out_valid,
    output logic signed [amc_pkg::FIELD_BITS-1:0]  out_value,
    output logic signed [amc_pkg::FIELD_BITS-1:0]  read_data
);
    import amc_pkg::*;

    mem_req_t mem_req;
    word_t    rd_data;
    logic     div_start;
    word_t    div_dividend;
    word_t    div_divisor;
    logic     div_busy;
    logic     div_done;
    word_t    div_quot;
    logic     res_free;
    logic     res_push;
    result_t  res;
    logic     res_valid_reg, res_valid_next;
    result_t  res_data_reg;

    amc_mem u_mem (
        .clk     (clk),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    amc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quot)
    );

    amc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .address      (address),
        .data         (data),
        .mem_req      (mem_req),
        .rd_data      (rd_data),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_done     (div_done),
        .div_quot     (div_quot),
        .res_free     (res_free),
        .res_push     (res_push),
        .res          (res)
    );

    // Output register: free when empty or draining this cycle.
    assign res_free = !res_valid_reg || res_ready;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (res_push)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            // drop the result once the transfer completes
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    // Hold the payload until a new result is pushed.
    always_ff @(posedge clk)
    begin
        if (res_push)
        begin
            res_data_reg <= res;
        end
    end

    assign res_valid = res_valid_reg;
    assign pc        = res_data_reg.pc;
    assign acc       = res_data_reg.acc;
    assign status    = res_data_reg.status;
    assign out_valid = res_data_reg.out_valid;
    assign out_value = res_data_reg.out_value;
    assign read_data = res_data_reg.read_data;

    a_push_only_free: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (!res_valid_reg || res_ready))
        else $error("result pushed over a pending result");

    a_push_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> res_valid_reg)
        else $error("pushed result not presented");

    a_out_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_data_reg.out_valid) |-> (res_data_reg.out_value == '0))
        else $error("out_value set without OUTPUT");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import amc_pkg::*;

    // Views of the machine state: one follows accepted transfers for checking,
    // the other runs ahead while the stimulus is built so that well-formed
    // programs can be steered away from halting.
    localparam int VIEW_CHECK = 0;
    localparam int VIEW_PLAN  = 1;

    localparam int ITEM_TARGET     = 1440;
    localparam int DIRECTED_STEPS  = 21;
    localparam int IDLE_LIMIT      = 3000;
    localparam int LONG_HOLD       = 300;
    localparam int HOLD_AFTER      = 400;
    localparam int SETTLE_CYCLES   = 60;
    localparam int DATA_SPAN       = 16;

    localparam word_t OP_NONE = word_t'(0);

    // data area used by the directed program and favored by random operands
    localparam addr_t A_DATA  = addr_t'(200);
    localparam addr_t A_ZERO  = addr_t'(200);
    localparam addr_t A_ONE   = addr_t'(201);
    localparam addr_t A_NEG1  = addr_t'(202);
    localparam addr_t A_MAX   = addr_t'(203);
    localparam addr_t A_MIN   = addr_t'(204);
    localparam addr_t A_NEG3  = addr_t'(205);
    localparam addr_t A_SEVEN = addr_t'(206);
    localparam addr_t A_S1    = addr_t'(207);
    localparam addr_t A_S2    = addr_t'(208);
    localparam addr_t A_S3    = addr_t'(209);

    typedef enum int {END_STOP, END_DIV0, END_ILLEGAL} ending_t;

    typedef struct {
        logic [KIND_BITS-1:0] kind;
        addr_t                address;
        word_t                data;
        bit                   drain_first;
    } cmd_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  req_valid = 1'b0;
    logic                  req_ready;
    logic [KIND_BITS-1:0]  req_kind  = KIND_WRITE;
    addr_t                 req_addr  = '0;
    word_t                 req_data  = '0;

    logic                          rsp_valid;
    logic                          rsp_ready = 1'b0;
    logic [PC_FIELD_BITS-1:0]      rsp_pc;
    logic signed [FIELD_BITS-1:0]  rsp_acc;
    logic [STATUS_BITS-1:0]        rsp_status;
    logic                          rsp_out_valid;
    logic signed [FIELD_BITS-1:0]  rsp_out_value;
    logic signed [FIELD_BITS-1:0]  rsp_read_data;

    // machine images, indexed by view
    word_t              ram_img  [2][MEM_DEPTH];
    addr_t              pc_img   [2];
    word_t              acc_img  [2];
    logic [STATUS_BITS-1:0] halt_img [2];
    word_t              boot_image [MEM_DEPTH];

    cmd_t    cmd_queue [$];
    result_t expected_state [$];

    logic req_taken = 1'b0;
    int   burst_left = 10;
    int   gap_left   = 0;
    int   hold_left  = 0;
    bit   hold_done  = 1'b0;
    int   stall_mode = 0;
    int   mode_left  = 0;
    int   idle_cycles = 0;

    int err_count       = 0;
    int results_checked = 0;
    int outputs_seen    = 0;
    int n_write = 0, n_exec = 0, n_read = 0;
    logic [STATUS_BITS-1:0] final_status = ST_RUN;

    accumulator_machine_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_ready  (req_ready),
        .kind      (req_kind),
        .address   (req_addr),
        .data      (req_data),
        .res_valid (rsp_valid),
        .res_ready (rsp_ready),
        .pc        (rsp_pc),
        .acc       (rsp_acc),
        .status    (rsp_status),
        .out_valid (rsp_out_valid),
        .out_value (rsp_out_value),
        .read_data (rsp_read_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Apply one item to a view of the machine and return the result it reports.
    function automatic result_t machine_step(int v, logic [KIND_BITS-1:0] k, addr_t ad,
                                             word_t d);
        result_t            r;
        word_t              op;
        word_t              m;
        addr_t              p;
        addr_t              a;
        addr_t              nxt;
        logic signed [31:0] q;
        bit                 moves;
        r = '0;
        if (k == KIND_WRITE)
        begin
            ram_img[v][ad] = d;
        end
        else if (k == KIND_READ)
        begin
            r.read_data = ram_img[v][ad];
        end
        else if (k == KIND_EXEC && halt_img[v] == ST_RUN)
        begin
            p     = pc_img[v];
            op    = ram_img[v][p];
            a     = addr_t'(ram_img[v][addr_t'(p + 1)]);
            m     = ram_img[v][a];
            nxt   = addr_t'(p + 2);
            moves = 1'b1;
            case (op)
                OP_ADD:  acc_img[v] = acc_img[v] + m;
                OP_SUB:  acc_img[v] = acc_img[v] - m;
                OP_MUL:  acc_img[v] = acc_img[v] * m;
                OP_DIV:
                begin
                    if (m == 0)
                    begin
                        halt_img[v] = ST_DIV0;
                        moves = 1'b0;
                    end
                    else
                    begin
                        // widen so the most negative word over -1 wraps back
                        q = acc_img[v];
                        q = q / m;
                        acc_img[v] = word_t'(q);
                    end
                end
                OP_JMP:  nxt = a;
                OP_JMPN: if (acc_img[v] < 0) nxt = a;
                OP_JMPP: if (acc_img[v] > 0) nxt = a;
                OP_JMPZ: if (acc_img[v] == 0) nxt = a;
                OP_COPY:
                begin
                    ram_img[v][addr_t'(ram_img[v][addr_t'(p + 2)])] = m;
                    nxt = addr_t'(p + 3);
                end
                OP_LOAD:   acc_img[v] = m;
                OP_STORE:  ram_img[v][a] = acc_img[v];
                OP_INPUT:  ram_img[v][a] = d;
                OP_OUTPUT:
                begin
                    r.out_valid = 1'b1;
                    r.out_value = m;
                end
                OP_STOP:
                begin
                    halt_img[v] = ST_STOP;
                    moves = 1'b0;
                end
                default:
                begin
                    halt_img[v] = ST_ILLEGAL;
                    moves = 1'b0;
                end
            endcase
            if (moves)
                pc_img[v] = nxt;
        end
        r.pc     = pc_img[v];
        r.acc    = acc_img[v];
        r.status = halt_img[v];
        return r;
    endfunction

    // Favor the extremes of a word, otherwise any pattern.
    function automatic word_t pick_word();
        case ($urandom_range(0, 9))
            0:       return word_t'(0);
            1:       return word_t'(1);
            2:       return word_t'(-1);
            3:       return word_t'(16'h7FFF);
            4:       return word_t'(16'h8000);
            default: return word_t'($urandom);
        endcase
    endfunction

    function automatic word_t pick_opcode();
        return word_t'($urandom_range(OP_ADD, OP_OUTPUT));
    endfunction

    // Operand word: random upper byte, so only the low address bits may count.
    function automatic word_t pick_operand(word_t op, addr_t p);
        addr_t t;
        if (op == OP_JMP || op == OP_JMPN || op == OP_JMPP || op == OP_JMPZ)
            t = ($urandom_range(0, 1) != 0) ? addr_t'(p + $urandom_range(0, 12))
                                            : addr_t'($urandom);
        else
            t = ($urandom_range(0, 3) != 0) ? addr_t'(A_DATA + $urandom_range(0, DATA_SPAN - 1))
                                            : addr_t'($urandom);
        return {8'($urandom), t};
    endfunction

    // True when the instruction at the planned pc runs without halting.
    function automatic bit next_is_safe();
        word_t op;
        addr_t p;
        addr_t a;
        p  = pc_img[VIEW_PLAN];
        op = ram_img[VIEW_PLAN][p];
        a  = addr_t'(ram_img[VIEW_PLAN][addr_t'(p + 1)]);
        if (op < OP_ADD || op > OP_OUTPUT)
            return 1'b0;
        return !(op == OP_DIV && ram_img[VIEW_PLAN][a] == 0);
    endfunction

    task automatic push_cmd(logic [KIND_BITS-1:0] k, addr_t ad, word_t d, bit drain);
        cmd_t c;
        c.kind        = k;
        c.address     = ad;
        c.data        = d;
        c.drain_first = drain;
        void'(machine_step(VIEW_PLAN, k, ad, d));
        cmd_queue = {cmd_queue, c};
    endtask

    task automatic lay(addr_t at, word_t op, addr_t target);
        boot_image[at]                = op;
        boot_image[addr_t'(at + 1)]   = {8'($urandom), target};
    endtask

    // Patch the instruction at the planned pc until it runs without halting.
    task automatic make_runnable();
        word_t op;
        addr_t p;
        while (!next_is_safe())
        begin
            p  = pc_img[VIEW_PLAN];
            op = pick_opcode();
            push_cmd(KIND_WRITE, addr_t'(p + 1), pick_operand(op, p), 1'b0);
            if (op == OP_COPY)
                push_cmd(KIND_WRITE, addr_t'(p + 2), pick_operand(op, p), 1'b0);
            push_cmd(KIND_WRITE, p, op, 1'b0);
        end
    endtask

    // Write a short program starting at the planned pc.
    task automatic write_block(int n);
        word_t op;
        addr_t p;
        p = pc_img[VIEW_PLAN];
        repeat (n)
        begin
            op = pick_opcode();
            push_cmd(KIND_WRITE, p, op, 1'b0);
            push_cmd(KIND_WRITE, addr_t'(p + 1), pick_operand(op, p), 1'b0);
            if (op == OP_COPY)
            begin
                push_cmd(KIND_WRITE, addr_t'(p + 2), pick_operand(op, p), 1'b0);
                p = addr_t'(p + 3);
            end
            else
            begin
                p = addr_t'(p + 2);
            end
        end
    endtask

    // Main sequence: build the stimulus, release reset, wait for the drain,
    // then report.
    initial
    begin
        ending_t ending;
        word_t   op;
        addr_t   p;
        addr_t   z;
        int      pick;

        for (int v = 0; v < 2; v++)
        begin
            pc_img[v]   = '0;
            acc_img[v]  = '0;
            halt_img[v] = ST_RUN;
        end

        // Memory image: random words, the extremes in the data area, and a
        // directed program at 0 that walks every opcode except STOP: wrap on
        // ADD/SUB/MUL, most negative over -1, truncating DIV of a negative,
        // taken and untaken branches, COPY, INPUT/OUTPUT, a jump near the top
        // and pc wrapping past the last word.
        for (int i = 0; i < MEM_DEPTH; i++)
            boot_image[i] = word_t'($urandom);
        boot_image[A_ZERO]  = word_t'(0);
        boot_image[A_ONE]   = word_t'(1);
        boot_image[A_NEG1]  = word_t'(-1);
        boot_image[A_MAX]   = word_t'(16'h7FFF);
        boot_image[A_MIN]   = word_t'(16'h8000);
        boot_image[A_NEG3]  = word_t'(-3);
        boot_image[A_SEVEN] = word_t'(7);
        lay(0,   OP_LOAD,   A_MAX);
        lay(2,   OP_ADD,    A_ONE);
        lay(4,   OP_JMPN,   8);
        lay(8,   OP_DIV,    A_NEG1);
        lay(10,  OP_SUB,    A_ONE);
        lay(12,  OP_JMPP,   16);
        lay(16,  OP_MUL,    A_MAX);
        lay(18,  OP_SUB,    A_ONE);
        lay(20,  OP_JMPZ,   24);
        lay(24,  OP_JMPN,   0);
        lay(26,  OP_JMPP,   0);
        lay(28,  OP_STORE,  A_S1);
        lay(30,  OP_INPUT,  A_S2);
        lay(32,  OP_COPY,   A_S2);
        boot_image[34] = {8'($urandom), A_S3};
        lay(35,  OP_LOAD,   A_S3);
        lay(37,  OP_OUTPUT, A_S3);
        lay(39,  OP_DIV,    A_NEG3);
        lay(41,  OP_JMP,    250);
        lay(250, OP_LOAD,   A_MIN);
        lay(252, OP_JMPZ,   0);
        lay(254, OP_ADD,    A_SEVEN);

        // Load every word first so nothing undefined is ever fetched or read.
        for (int i = 0; i < MEM_DEPTH; i++)
            push_cmd(KIND_WRITE, addr_t'(i), boot_image[i], 1'b0);

        // Step through the directed program; INPUT takes a negative value so
        // the later DIV truncates toward zero.
        repeat (DIRECTED_STEPS)
        begin
            if (ram_img[VIEW_PLAN][pc_img[VIEW_PLAN]] == OP_INPUT)
                push_cmd(KIND_EXEC, '0, word_t'(-7), 1'b0);
            else
                push_cmd(KIND_EXEC, addr_t'($urandom), pick_word(), 1'b0);
        end
        push_cmd(KIND_READ, A_MIN, word_t'($urandom), 1'b0);
        push_cmd(KIND_READ, A_S3, word_t'($urandom), 1'b0);
        push_cmd(KIND_READ, addr_t'(MEM_DEPTH - 1), word_t'($urandom), 1'b0);

        // Random part: mostly running programs, with fresh code, data writes
        // that may land on code, reads, and an occasional drained pause.
        while (cmd_queue.size() < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 62)
            begin
                make_runnable();
                push_cmd(KIND_EXEC, addr_t'($urandom), pick_word(), 1'b0);
            end
            else if (pick < 70)
            begin
                write_block($urandom_range(2, 8));
            end
            else if (pick < 82)
            begin
                if ($urandom_range(0, 3) != 0)
                    push_cmd(KIND_WRITE, addr_t'(A_DATA + $urandom_range(0, DATA_SPAN - 1)),
                             pick_word(), 1'b0);
                else
                    push_cmd(KIND_WRITE, addr_t'($urandom), pick_word(), 1'b0);
            end
            else if (pick < 97)
            begin
                push_cmd(KIND_READ, addr_t'($urandom), word_t'($urandom), 1'b0);
            end
            else
            begin
                push_cmd(KIND_READ, addr_t'($urandom), word_t'($urandom), 1'b1);
            end
        end

        // Halt the machine once, in one of its three ways, after a full drain.
        ending = ending_t'($urandom_range(0, 2));
        p = pc_img[VIEW_PLAN];
        push_cmd(KIND_READ, p, word_t'($urandom), 1'b1);
        case (ending)
            END_STOP:
            begin
                push_cmd(KIND_WRITE, addr_t'(p + 1), pick_word(), 1'b0);
                op = OP_STOP;
            end
            END_DIV0:
            begin
                z = addr_t'(p + 2);
                push_cmd(KIND_WRITE, z, word_t'(0), 1'b0);
                push_cmd(KIND_WRITE, addr_t'(p + 1), {8'($urandom), z}, 1'b0);
                op = OP_DIV;
            end
            default:
            begin
                push_cmd(KIND_WRITE, addr_t'(p + 1), pick_word(), 1'b0);
                case ($urandom_range(0, 2))
                    0:       op = OP_NONE;
                    1:       op = word_t'($urandom_range(OP_STOP + 1, 16'h7FFF));
                    default: op = word_t'(16'h8000 | $urandom);
                endcase
            end
        endcase
        push_cmd(KIND_WRITE, p, op, 1'b0);
        repeat (4)
            push_cmd(KIND_EXEC, addr_t'($urandom), pick_word(), 1'b0);
        // memory access must still work while halted
        z = addr_t'($urandom);
        push_cmd(KIND_WRITE, z, pick_word(), 1'b0);
        push_cmd(KIND_READ, z, word_t'($urandom), 1'b0);
        push_cmd(KIND_EXEC, z, pick_word(), 1'b0);

        // Hold reset, then release it away from both clock edges.
        repeat (9) @(posedge clk);
        #5 rst_n = 1'b1;

        // Sample at the rising edge, where the sender's queue and valid agree.
        while (cmd_queue.size() != 0 || req_valid || expected_state.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        $display("Covered %0d writes, %0d executes and %0d reads; %0d results checked.",
                 n_write, n_exec, n_read, results_checked);
        $display("OUTPUT produced %0d values; machine ended with halt code %0d.",
                 outputs_seen, final_status);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Sender: take the next item whenever the port is free, in bursts with
    // random gaps. An item flagged for a drain waits until every expected
    // result has come back.
    always @(negedge clk)
    begin
        cmd_t c;
        if (rst_n && (!req_valid || req_taken))
        begin
            if (gap_left != 0)
            begin
                gap_left  <= gap_left - 1;
                req_valid <= 1'b0;
            end
            else if (cmd_queue.size() != 0 &&
                     !(cmd_queue[0].drain_first && expected_state.size() != 0))
            begin
                c = cmd_queue.pop_front();
                req_valid <= 1'b1;
                req_kind  <= c.kind;
                req_addr  <= c.address;
                req_data  <= c.data;
                if (burst_left > 1)
                begin
                    burst_left <= burst_left - 1;
                end
                else
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                end
            end
            else
            begin
                req_valid <= 1'b0;
            end
        end
    end

    // Receiver: switch between stall patterns now and then, and once hold
    // ready low for a long stretch so the core backs up into its input.
    always @(negedge clk)
    begin
        logic go;
        go = 1'b0;
        if (rst_n)
        begin
            if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
            end
            else if (!hold_done && results_checked >= HOLD_AFTER)
            begin
                hold_left <= LONG_HOLD;
                hold_done <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode <= $urandom_range(0, 3);
                    mode_left  <= $urandom_range(20, 200);
                end
                else
                begin
                    mode_left <= mode_left - 1;
                end
                case (stall_mode)
                    0:       go = 1'b1;
                    1:       go = ($urandom_range(0, 1) != 0);
                    2:       go = ($urandom_range(0, 3) == 0);
                    default: go = ($urandom_range(0, 9) != 0);
                endcase
            end
        end
        rsp_ready <= go;
    end

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            err_count++;
        end
    endtask

    // Monitor: check each result transfer against the oldest expectation,
    // then predict the result of an accepted item.
    always @(posedge clk)
    begin
        result_t want;
        req_taken <= req_valid && req_ready;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_state.size() == 0)
            begin
                $display("%0t: result with nothing expected, actual pc %0d acc %0d status %0d",
                         $time, rsp_pc, rsp_acc, rsp_status);
                err_count++;
            end
            else
            begin
                want = expected_state.pop_front();
                compare_field("pc",        want.pc,        rsp_pc);
                compare_field("acc",       want.acc,       rsp_acc);
                compare_field("status",    want.status,    rsp_status);
                compare_field("out_valid", want.out_valid, rsp_out_valid);
                compare_field("out_value", want.out_value, rsp_out_value);
                compare_field("read_data", want.read_data, rsp_read_data);
                results_checked++;
            end
            if (rsp_out_valid)
                outputs_seen++;
            final_status = rsp_status;
        end
        if (rst_n && req_valid && req_ready)
        begin
            expected_state = {expected_state,
                              machine_step(VIEW_CHECK, req_kind, req_addr, req_data)};
            case (req_kind)
                KIND_WRITE: n_write++;
                KIND_EXEC:  n_exec++;
                default:    n_read++;
            endcase
        end
    end

    // Watchdog: end the run when no transfer happens for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles == IDLE_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

>>> sim.f
sv/amc_pkg.sv
sv/amc_mem.sv
sv/amc_div.sv
sv/amc_ctrl.sv
sv/accumulator_machine_core.sv
tb/tb.sv
